// File: hdl/fhd_pkg.sv
package fhd_pkg;

	localparam int unsigned HEADER_BYTES = 22;
	localparam int unsigned POS_W        = 17;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// header byte offsets at which each field begins
	localparam int unsigned OFF_VERSION = 2;
	localparam int unsigned OFF_FLAGS   = 3;
	localparam int unsigned OFF_SEQ     = 12;
	localparam int unsigned OFF_ACK     = 16;
	localparam int unsigned OFF_LENGTH  = 20;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MAGIC   = 2'd0,
		REG_VERSION = 2'd1,
		REG_MAX_LEN = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TOO_SHORT   = 3'd1,
		ST_BAD_MAGIC   = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_BAD_LENGTH  = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_datagram;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  payload_byte;
		logic [2:0]  status;
		logic [63:0] session_id;
		logic [31:0] sequence_number;
		logic [31:0] ack_number;
		logic [7:0]  frame_flags;
		logic [15:0] payload_length;
		logic        last_of_frame;
	} out_item_t;

	// one queue entry: what a single accepted byte asks the back end to send
	typedef struct packed {
		logic       has_payload;
		logic [7:0] payload_byte;
		logic       has_status;
		out_item_t  status_item;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

// File: hdl/fhd_front.sv
module fhd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  fhd_pkg::in_item_t                 in_item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fhd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [fhd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  fhd_pkg::qstat_t                   qstat,
	output logic                              push,
	output fhd_pkg::cmd_t                     push_cmd
);

	logic [15:0] exp_magic_q;
	logic [7:0]  exp_version_q;
	logic [15:0] max_len_q;

	logic [fhd_pkg::POS_W-1:0] pos_q;
	logic [15:0] magic_q;
	logic [7:0]  version_q;
	logic [7:0]  flags_q;
	logic [63:0] session_q;
	logic [31:0] seq_q;
	logic [31:0] ack_q;
	logic [15:0] len_q;

	logic [fhd_pkg::POS_W-1:0] pos_nxt;
	logic [15:0] magic_nxt;
	logic [7:0]  version_nxt;
	logic [7:0]  flags_nxt;
	logic [63:0] session_nxt;
	logic [31:0] seq_nxt;
	logic [31:0] ack_nxt;
	logic [15:0] len_nxt;

	logic in_header;
	logic accept;
	logic last;
	logic [fhd_pkg::POS_W-1:0] total_expected;
	fhd_pkg::status_t verdict;

	assign cfg_ready = 1'b1;
	assign in_stall  = qstat.full;
	assign accept    = in_valid && !qstat.full;
	assign last      = in_item.end_of_datagram;
	assign in_header = pos_q < fhd_pkg::POS_W'(fhd_pkg::HEADER_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_magic_q   <= '0;
			exp_version_q <= '0;
			max_len_q     <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fhd_pkg::REG_MAGIC:   exp_magic_q   <= cfg_data;
				fhd_pkg::REG_VERSION: exp_version_q <= cfg_data[7:0];
				fhd_pkg::REG_MAX_LEN: max_len_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// header capture, shifting big-endian bytes into the field they belong to
	always_comb begin
		magic_nxt   = magic_q;
		version_nxt = version_q;
		flags_nxt   = flags_q;
		session_nxt = session_q;
		seq_nxt     = seq_q;
		ack_nxt     = ack_q;
		len_nxt     = len_q;
		if (in_header) begin
			priority if (pos_q < fhd_pkg::POS_W'(fhd_pkg::OFF_VERSION))
				magic_nxt = {magic_q[7:0], in_item.data_byte};
			else if (pos_q == fhd_pkg::POS_W'(fhd_pkg::OFF_VERSION))
				version_nxt = in_item.data_byte;
			else if (pos_q == fhd_pkg::POS_W'(fhd_pkg::OFF_FLAGS))
				flags_nxt = in_item.data_byte;
			else if (pos_q < fhd_pkg::POS_W'(fhd_pkg::OFF_SEQ))
				session_nxt = {session_q[55:0], in_item.data_byte};
			else if (pos_q < fhd_pkg::POS_W'(fhd_pkg::OFF_ACK))
				seq_nxt = {seq_q[23:0], in_item.data_byte};
			else if (pos_q < fhd_pkg::POS_W'(fhd_pkg::OFF_LENGTH))
				ack_nxt = {ack_q[23:0], in_item.data_byte};
			else
				len_nxt = {len_q[7:0], in_item.data_byte};
		end
		pos_nxt = (pos_q == fhd_pkg::POS_MAX) ? pos_q : pos_q + 1'b1;
	end

	assign total_expected = fhd_pkg::POS_W'(len_nxt) + fhd_pkg::POS_W'(fhd_pkg::HEADER_BYTES);

	always_comb begin
		priority if (pos_nxt < fhd_pkg::POS_W'(fhd_pkg::HEADER_BYTES))
			verdict = fhd_pkg::ST_TOO_SHORT;
		else if (magic_nxt != exp_magic_q)
			verdict = fhd_pkg::ST_BAD_MAGIC;
		else if (version_nxt != exp_version_q)
			verdict = fhd_pkg::ST_BAD_VERSION;
		else if (len_nxt > max_len_q || total_expected != pos_nxt)
			verdict = fhd_pkg::ST_BAD_LENGTH;
		else
			verdict = fhd_pkg::ST_OK;
	end

	always_comb begin
		push_cmd                  = '0;
		push_cmd.has_payload      = !in_header;
		push_cmd.payload_byte     = in_item.data_byte;
		push_cmd.has_status       = last;
		push_cmd.status_item.result_kind   = fhd_pkg::KIND_STATUS;
		push_cmd.status_item.status        = verdict;
		push_cmd.status_item.last_of_frame = 1'b1;
		if (verdict != fhd_pkg::ST_TOO_SHORT) begin
			push_cmd.status_item.session_id      = session_nxt;
			push_cmd.status_item.sequence_number = seq_nxt;
			push_cmd.status_item.ack_number      = ack_nxt;
			push_cmd.status_item.frame_flags     = flags_nxt;
			push_cmd.status_item.payload_length  = len_nxt;
		end
	end

	assign push = accept && (!in_header || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			magic_q   <= '0;
			version_q <= '0;
			flags_q   <= '0;
			session_q <= '0;
			seq_q     <= '0;
			ack_q     <= '0;
			len_q     <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q     <= '0;
				magic_q   <= '0;
				version_q <= '0;
				flags_q   <= '0;
				session_q <= '0;
				seq_q     <= '0;
				ack_q     <= '0;
				len_q     <= '0;
			end else begin
				pos_q     <= pos_nxt;
				magic_q   <= magic_nxt;
				version_q <= version_nxt;
				flags_q   <= flags_nxt;
				session_q <= session_nxt;
				seq_q     <= seq_nxt;
				ack_q     <= ack_nxt;
				len_q     <= len_nxt;
			end
		end
	end

endmodule

// File: hdl/fhd_queue.sv
module fhd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fhd_pkg::cmd_t   push_cmd,
	input  logic            pop,
	output fhd_pkg::cmd_t   head,
	output fhd_pkg::qstat_t qstat
);

	fhd_pkg::cmd_t entry_q [fhd_pkg::QUEUE_DEPTH];
	logic [fhd_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [fhd_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [fhd_pkg::QUEUE_AW:0]   count_q;

	assign qstat.empty = count_q == '0;
	assign qstat.full  = count_q == (fhd_pkg::QUEUE_AW+1)'(fhd_pkg::QUEUE_DEPTH);
	assign head        = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// File: hdl/fhd_back.sv
module fhd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  fhd_pkg::cmd_t       head,
	input  fhd_pkg::qstat_t     qstat,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_stall,
	output fhd_pkg::out_item_t  res_item
);

	logic               res_valid_q;
	fhd_pkg::out_item_t res_item_q;
	logic               pay_done_q;
	logic               pay_done_nxt;
	logic               load;
	fhd_pkg::out_item_t emit;

	assign load      = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// a final byte past the header sends its payload first, then the status
	always_comb begin
		pop          = 1'b0;
		pay_done_nxt = pay_done_q;
		emit         = head.status_item;
		if (load && !qstat.empty) begin
			if (head.has_payload && !pay_done_q) begin
				emit              = '0;
				emit.result_kind  = fhd_pkg::KIND_PAYLOAD;
				emit.payload_byte = head.payload_byte;
				if (head.has_status)
					pay_done_nxt = 1'b1;
				else
					pop = 1'b1;
			end else begin
				pop          = 1'b1;
				pay_done_nxt = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pay_done_q  <= 1'b0;
		end else begin
			pay_done_q <= pay_done_nxt;
			if (load)
				res_valid_q <= !qstat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !qstat.empty)
			res_item_q <= emit;
	end

endmodule

// File: hdl/frame_header_deframer.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------
// in       | input     | in_valid / in_stall    | in_item  (data_byte, end mark)
// res      | output    | res_valid / res_stall  | res_item (payload or status)
// cfg      | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low. A byte that yields a result
// is written into the command queue, then loaded into the output register.
// A final byte past the header yields two results, which the output stage
// sends one after the other; the four-entry command queue absorbs the extra one.
// in_stall rises only when the command queue is full; cfg_ready is always high.
// arst_n clears the byte counter, header capture, queue and output valid, and
// returns the registers to magic 0, version 0, max length 65535.
module frame_header_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  fhd_pkg::in_item_t                 in_item,
	output logic                              res_valid,
	input  logic                              res_stall,
	output fhd_pkg::out_item_t                res_item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fhd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [fhd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// front end -> queue
	logic            push;
	fhd_pkg::cmd_t   push_cmd;
	// queue -> both ends
	fhd_pkg::qstat_t qstat;
	fhd_pkg::cmd_t   head;
	logic            pop;

	// parses the header, holds the registers and judges the frame on its end mark
	fhd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// decouples parsing from output backpressure
	fhd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// expands each command into one or two result transactions
	fhd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

// File: hdl/fhd_checker.sv
module fhd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input fhd_pkg::out_item_t res_item
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.result_kind == fhd_pkg::KIND_STATUS
		|-> res_item.last_of_frame && res_item.payload_byte == '0)
		else $error("status transaction malformed");

	a_payload_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.result_kind == fhd_pkg::KIND_PAYLOAD
		|-> !res_item.last_of_frame && res_item.session_id == '0
		&& res_item.payload_length == '0 && res_item.status == 3'(fhd_pkg::ST_OK))
		else $error("payload transaction carries header data");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.result_kind == fhd_pkg::KIND_STATUS
		&& res_item.status == 3'(fhd_pkg::ST_TOO_SHORT)
		|-> res_item.session_id == '0 && res_item.sequence_number == '0
		&& res_item.ack_number == '0 && res_item.frame_flags == '0)
		else $error("short frame reports header fields");

endmodule

bind frame_header_deframer fhd_checker u_fhd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);
